FILE: rtl/core/nkrl_pkg.sv
// Shared types and constants for the top-N keyed ranking list.
// No dependencies; used by nkrl_cell and top_n_keyed_ranking_list.
`default_nettype none

package nkrl_pkg;

  localparam int KEY_W   = 32;
  localparam int SCORE_W = 32;
  localparam int INFO_W  = 32;
  localparam int CNT_W   = 7;
  localparam int POS_W   = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ENABLED      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIST_SIZE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOWEST_FIRST = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0]          key;
    logic signed [SCORE_W-1:0] score;
    logic [INFO_W-1:0]         info;
  } entry_t;

  // How the row of cells is rewritten for one update.
  typedef enum logic [2:0] {
    MODE_NONE,
    MODE_SET,
    MODE_UP,
    MODE_DOWN,
    MODE_INS
  } mode_e;

  typedef struct packed {
    mode_e mode;
    logic  cmp;
    logic  load;
  } cell_ctl_t;

  // Per-cell compare results, captured in the cycle before the row is rewritten.
  typedef struct packed {
    logic match;
    logic new_beats;
    logic old_beats;
  } cell_flags_t;

  function automatic logic beats(input logic signed [SCORE_W-1:0] a,
                                 input logic signed [SCORE_W-1:0] b,
                                 input logic                      lowest_first);
    beats = lowest_first ? (a < b) : (a > b);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/nkrl_cell.sv
// One slot of the ranking list: holds an entry, compares it with the update word
// and takes its next contents from the update word or a neighbor. Uses nkrl_pkg.
`default_nettype none

module nkrl_cell import nkrl_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire entry_t      item_i,
  input  wire logic        lowest_first_i,
  input  wire logic        valid_i,
  input  wire logic        at_held_i,
  input  wire logic        anchor_i,
  input  wire cell_ctl_t   ctl_i,
  input  wire entry_t      prev_ent_i,
  input  wire entry_t      next_ent_i,
  input  wire logic        up_prev_i,
  input  wire logic        up_next_i,
  input  wire logic        dn_prev_i,
  input  wire logic        dn_next_i,
  input  wire logic        before_i,
  output logic             up_o,
  output logic             dn_o,
  output logic             before_o,
  output logic             new_o,
  output logic             hit_o,
  output cell_flags_t      flags_o,
  output entry_t           ent_o
);

  entry_t      ent_q, ent_d;
  cell_flags_t flags_q;
  logic        ins_hit, ins_region;
  logic        take_new, take_prev, take_next;

  assign hit_o   = valid_i && (ent_q.key == item_i.key);
  assign ent_o   = ent_q;
  assign flags_o = flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (ctl_i.cmp) begin
      flags_q.match     <= hit_o;
      flags_q.new_beats <= beats(item_i.score, ent_q.score, lowest_first_i);
      flags_q.old_beats <= beats(ent_q.score, item_i.score, lowest_first_i);
    end
  end

  // Upward move: the region runs from the anchor toward the head while the new
  // score beats each slot. Downward move is the mirror image.
  assign up_o = anchor_i || (up_next_i && valid_i && flags_q.new_beats);
  assign dn_o = anchor_i || (dn_prev_i && valid_i && flags_q.old_beats);

  // Insertion goes at the first held slot the new score beats, else at the end.
  assign ins_hit    = valid_i && flags_q.new_beats;
  assign before_o   = before_i || ins_hit;
  assign ins_region = (valid_i || at_held_i) && (before_i || ins_hit || at_held_i);

  always_comb begin
    take_new  = 1'b0;
    take_prev = 1'b0;
    take_next = 1'b0;
    case (ctl_i.mode)
      MODE_SET: begin
        take_new = anchor_i;
      end
      MODE_UP: begin
        take_new  = up_o && !up_prev_i;
        take_prev = up_o && up_prev_i;
      end
      MODE_DOWN: begin
        take_new  = dn_o && !dn_next_i;
        take_next = dn_o && dn_next_i;
      end
      MODE_INS: begin
        take_new  = ins_region && !before_i;
        take_prev = ins_region && before_i;
      end
      default: begin
        take_new = 1'b0;
      end
    endcase
  end

  assign new_o = take_new;

  always_comb begin
    if (take_new) begin
      ent_d = item_i;
    end else if (take_prev) begin
      ent_d = prev_ent_i;
    end else if (take_next) begin
      ent_d = next_ent_i;
    end else begin
      ent_d = ent_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      ent_q <= ent_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/top_n_keyed_ranking_list.sv
// Top level of the top-N keyed ranking list: control, a row of nkrl_cell slots,
// configuration registers and the output register. Uses nkrl_pkg.
//
//  channel  | handshake                  | word
//  ---------+----------------------------+----------------------------------------
//  input    | in_valid_i / in_stall_o    | entry_key_i, entry_score_i, entry_info_i
//  output   | out_valid_o / out_stall_i  | in_list_o, position_o, entry_count_o,
//           |                            | min_score_o
//  config   | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// An update runs in order: compare in every cell, rewrite the row, then look up
// the key and the last score. The next word is taken in the lookup step, so a
// new word is accepted as the last result is registered. The output register
// holds the result while out_stall_i is high; the lookup step waits only if it
// is still full. Reset empties the list; slot contents are not cleared.
`default_nettype none

module top_n_keyed_ranking_list import nkrl_pkg::*; #(
  parameter int MAX_ENTRIES = 64
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [KEY_W-1:0]          entry_key_i,
  input  wire logic signed [SCORE_W-1:0] entry_score_i,
  input  wire logic [INFO_W-1:0]         entry_info_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic                           in_list_o,
  output logic [POS_W-1:0]               position_o,
  output logic [CNT_W-1:0]               entry_count_o,
  output logic signed [SCORE_W-1:0]      min_score_o,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]     cfg_data_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]       st_q, st_d;
  logic             enabled_q, lowest_first_q;
  logic [CNT_W-1:0] list_size_q, held_q, held_d, cap;
  entry_t           item_q;
  logic             in_acc, out_free;

  logic                      out_valid_q;
  logic                      in_list_q;
  logic [POS_W-1:0]          position_q;
  logic [CNT_W-1:0]          count_q;
  logic signed [SCORE_W-1:0] min_q;

  cell_ctl_t   ctl;
  mode_e       mode;
  entry_t      ents [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] up_v, dn_v, new_v, hit_v, valid_v, last_v, anchor_v;
  logic [MAX_ENTRIES-1:0] match_v, nb_v, ob_v;
  logic [MAX_ENTRIES:0]   before_v;

  logic                      found, anchor_up, anchor_down, last_beaten;
  logic                      listed, full;
  logic [POS_W-1:0]          pos;
  logic signed [SCORE_W-1:0] last_score;

  // ---------------- configuration ----------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q      <= 1'b0;
      list_size_q    <= CNT_W'(64);
      lowest_first_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_ENABLED:      enabled_q      <= cfg_data_i[0];
        REG_LIST_SIZE:    list_size_q    <= cfg_data_i;
        REG_LOWEST_FIRST: lowest_first_q <= cfg_data_i[0];
        default:          enabled_q      <= enabled_q;
      endcase
    end
  end

  always_comb begin
    if (list_size_q == '0) begin
      cap = CNT_W'(1);
    end else if (int'(list_size_q) > MAX_ENTRIES) begin
      cap = CNT_W'(MAX_ENTRIES);
    end else begin
      cap = list_size_q;
    end
  end

  // ---------------- sequencing ----------------
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((st_q == ST_IDLE) || ((st_q == ST_OUT) && out_free));
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: if (in_acc) st_d = ST_CMP;
      ST_CMP:  st_d = ST_UPD;
      ST_UPD:  st_d = ST_OUT;
      ST_OUT: begin
        if (out_free) st_d = in_acc ? ST_CMP : ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      held_q <= '0;
    end else begin
      st_q   <= st_d;
      held_q <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q.key   <= entry_key_i;
      item_q.score <= entry_score_i;
      item_q.info  <= entry_info_i;
    end
  end

  // ---------------- update decision ----------------
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      valid_v[i] = i < int'(held_q);
      last_v[i]  = (held_q != '0) && (i == int'(held_q) - 1);
    end
  end

  assign found       = |match_v;
  assign anchor_up   = |(match_v & nb_v);
  assign anchor_down = |(match_v & ob_v);
  assign last_beaten = |(last_v & nb_v);
  assign anchor_v    = found ? match_v : last_v;

  always_comb begin
    mode = MODE_NONE;
    if (enabled_q) begin
      if (found) begin
        if (anchor_up) begin
          mode = MODE_UP;
        end else if (anchor_down) begin
          mode = MODE_DOWN;
        end else begin
          mode = MODE_SET;
        end
      end else if (held_q < cap) begin
        mode = MODE_INS;
      end else if (last_beaten) begin
        // Full list: the word pushes out the last entry and climbs from there.
        mode = MODE_UP;
      end
    end
  end

  assign ctl.mode = mode;
  assign ctl.cmp  = (st_q == ST_CMP);
  assign ctl.load = (st_q == ST_UPD);

  assign held_d = ((st_q == ST_UPD) && (mode == MODE_INS)) ? held_q + CNT_W'(1) : held_q;

  // ---------------- row of cells ----------------
  assign before_v[0] = 1'b0;

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    entry_t      prev_ent, next_ent;
    logic        up_prev, up_next, dn_prev, dn_next;
    cell_flags_t cell_flags;

    if (g == 0) begin : g_head
      assign prev_ent = item_q;
      assign up_prev  = 1'b0;
      assign dn_prev  = 1'b0;
    end else begin : g_mid
      assign prev_ent = ents[g-1];
      assign up_prev  = up_v[g-1];
      assign dn_prev  = dn_v[g-1];
    end

    if (g == MAX_ENTRIES - 1) begin : g_tail
      assign next_ent = item_q;
      assign up_next  = 1'b0;
      assign dn_next  = 1'b0;
    end else begin : g_body
      assign next_ent = ents[g+1];
      assign up_next  = up_v[g+1];
      assign dn_next  = dn_v[g+1];
    end

    nkrl_cell u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .item_i         (item_q),
      .lowest_first_i (lowest_first_q),
      .valid_i        (valid_v[g]),
      .at_held_i      (g == int'(held_q)),
      .anchor_i       (anchor_v[g]),
      .ctl_i          (ctl),
      .prev_ent_i     (prev_ent),
      .next_ent_i     (next_ent),
      .up_prev_i      (up_prev),
      .up_next_i      (up_next),
      .dn_prev_i      (dn_prev),
      .dn_next_i      (dn_next),
      .before_i       (before_v[g]),
      .up_o           (up_v[g]),
      .dn_o           (dn_v[g]),
      .before_o       (before_v[g+1]),
      .new_o          (new_v[g]),
      .hit_o          (hit_v[g]),
      .flags_o        (cell_flags),
      .ent_o          (ents[g])
    );

    assign match_v[g] = cell_flags.match;
    assign nb_v[g]    = cell_flags.new_beats;
    assign ob_v[g]    = cell_flags.old_beats;
  end

  // ---------------- result ----------------
  always_comb begin
    pos        = '0;
    last_score = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (hit_v[i]) pos = pos | POS_W'(i);
      if (last_v[i]) last_score = last_score | ents[i].score;
    end
  end

  assign listed = |hit_v;
  assign full   = (held_q != '0) && (held_q >= cap);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((st_q == ST_OUT) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((st_q == ST_OUT) && out_free) begin
      in_list_q  <= listed;
      position_q <= listed ? pos : '0;
      count_q    <= held_q;
      min_q      <= full ? last_score : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign in_list_o     = in_list_q;
  assign position_o    = position_q;
  assign entry_count_o = count_q;
  assign min_score_o   = min_q;

`ifndef SYNTHESIS
  // The fill count only ever steps up by one, and only when the row is rewritten.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q != $past(held_q)) |->
      (($past(st_q) == ST_UPD) && (held_q == $past(held_q) + CNT_W'(1))))
    else $error("fill count changed outside an insertion");

  // Every rewrite in an update mode places the update word in exactly one slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((st_q == ST_UPD) && (mode != MODE_NONE)) |-> $onehot(new_v))
    else $error("update word placed in zero or several slots");

  // A key is held in at most one slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_OUT) |-> $onehot0(hit_v))
    else $error("key found in more than one slot");

  // A result word is only loaded from the lookup step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(st_q) == ST_OUT))
    else $error("result raised outside the lookup step");
`endif

endmodule

`default_nettype wire
